### src/cbcs_pkg.sv
// Shared types and constants for the cubic Bezier curve sampler.
package cbcs_pkg;

  localparam int PC_W = 7;
  localparam logic [PC_W-1:0] PC_RESET = 7'd16;
  localparam int PC_MIN = 2;
  localparam int IDX_W = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RUN
  } cbcs_state_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] index;
  } cbcs_tag_t;

endpackage

### src/cbcs_if.sv
// Request channel interfaces: control points in, curve points out.
interface cbcs_in_if #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] start_z;
  logic signed [COORD_WIDTH-1:0] handle_a_x;
  logic signed [COORD_WIDTH-1:0] handle_a_y;
  logic signed [COORD_WIDTH-1:0] handle_a_z;
  logic signed [COORD_WIDTH-1:0] handle_b_x;
  logic signed [COORD_WIDTH-1:0] handle_b_y;
  logic signed [COORD_WIDTH-1:0] handle_b_z;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;
  logic signed [COORD_WIDTH-1:0] end_z;

  modport source (
    output valid, start_x, start_y, start_z, handle_a_x, handle_a_y, handle_a_z,
           handle_b_x, handle_b_y, handle_b_z, end_x, end_y, end_z,
    input  ready
  );

  modport sink (
    input  valid, start_x, start_y, start_z, handle_a_x, handle_a_y, handle_a_z,
           handle_b_x, handle_b_y, handle_b_z, end_x, end_y, end_z,
    output ready
  );
endinterface

interface cbcs_out_if import cbcs_pkg::*; #(parameter int COORD_WIDTH = 32);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] curve_x;
  logic signed [COORD_WIDTH-1:0] curve_y;
  logic signed [COORD_WIDTH-1:0] curve_z;
  logic [IDX_W-1:0]              sample_index;
  logic                          last_point;

  modport source (
    output valid, curve_x, curve_y, curve_z, sample_index, last_point,
    input  ready
  );

  modport sink (
    input  valid, curve_x, curve_y, curve_z, sample_index, last_point,
    output ready
  );
endinterface

### src/cbcs_div.sv
// Restoring divider, one quotient bit per cycle: 2^FRAC_BITS / divisor.
module cbcs_div #(
  parameter int FRAC_BITS = 16,
  parameter int DW        = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DW-1:0]        divisor,
  output logic                 done,
  output logic [FRAC_BITS:0]   quot,
  output logic [DW-1:0]        rem
);

  localparam int CTW = $clog2(FRAC_BITS + 1);

  logic [CTW-1:0]     cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DW-1:0]      rem_r, rem_nxt;
  logic [FRAC_BITS:0] quot_r, quot_nxt;
  logic [DW:0]        shifted;
  logic [DW:0]        diff;
  logic               ge;

  always_comb begin
    shifted = {rem_r, (cnt_r == CTW'(FRAC_BITS))};
    ge      = shifted >= {1'b0, divisor};
    diff    = shifted - {1'b0, divisor};

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CTW'(FRAC_BITS);
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[DW-1:0] : shifted[DW-1:0];
      quot_nxt = {quot_r[FRAC_BITS-1:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign rem  = rem_r;

endmodule

### src/cbcs_weight.sv
// Two-stage Bernstein weight pipeline: t -> (u^2, t^2) -> w0..w3.
module cbcs_weight import cbcs_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [FRAC_BITS:0]     t_in,
  input  cbcs_tag_t              tag_in,
  output logic [FRAC_BITS+1:0]   w_out [4],
  output cbcs_tag_t              tag_out,
  output logic                   busy
);

  localparam int TW  = FRAC_BITS + 1;
  localparam int WW  = FRAC_BITS + 2;
  localparam int PW  = 2 * FRAC_BITS + 2;
  localparam int P3W = 2 * FRAC_BITS + 3;
  localparam logic [TW-1:0] ONE  = {1'b1, {FRAC_BITS{1'b0}}};
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic [TW-1:0]  u;
  logic [PW-1:0]  uu_sum, tt_sum;
  logic [TW-1:0]  uu_r, tt_r, t1_r, u1_r;
  cbcs_tag_t      tag1_r, tag2_r;
  logic [PW-1:0]  m0, m1, m2, m3;
  logic [PW-1:0]  s0, s3;
  logic [P3W-1:0] s1, s2;
  logic [WW-1:0]  w_r [4];

  // stage 1: squares
  always_comb begin
    u      = ONE - t_in;
    uu_sum = PW'(u) * PW'(u) + HALF;
    tt_sum = PW'(t_in) * PW'(t_in) + HALF;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
    end else if (en) begin
      tag1_r <= tag_in;
    end
    if (en) begin
      uu_r <= uu_sum[2*FRAC_BITS:FRAC_BITS];
      tt_r <= tt_sum[2*FRAC_BITS:FRAC_BITS];
      t1_r <= t_in;
      u1_r <= u;
    end
  end

  // stage 2: cubes, middle terms scaled by 3
  always_comb begin
    m0 = PW'(uu_r) * PW'(u1_r);
    m1 = PW'(uu_r) * PW'(t1_r);
    m2 = PW'(tt_r) * PW'(u1_r);
    m3 = PW'(tt_r) * PW'(t1_r);
    s0 = m0 + HALF;
    s3 = m3 + HALF;
    s1 = (P3W'(m1) << 1) + P3W'(m1) + P3W'(HALF);
    s2 = (P3W'(m2) << 1) + P3W'(m2) + P3W'(HALF);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag2_r <= '0;
    end else if (en) begin
      tag2_r <= tag1_r;
    end
    if (en) begin
      w_r[0] <= WW'(s0[2*FRAC_BITS:FRAC_BITS]);
      w_r[1] <= s1[2*FRAC_BITS+1:FRAC_BITS];
      w_r[2] <= s2[2*FRAC_BITS+1:FRAC_BITS];
      w_r[3] <= WW'(s3[2*FRAC_BITS:FRAC_BITS]);
    end
  end

  assign w_out   = w_r;
  assign tag_out = tag2_r;
  assign busy    = tag1_r.valid || tag2_r.valid;

endmodule

### src/cbcs_lane.sv
// One coordinate lane: four weighted products, floor to grid, saturate.
module cbcs_lane #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [COORD_WIDTH-1:0] p [4],
  input  logic [FRAC_BITS+1:0]          w [4],
  output logic signed [COORD_WIDTH-1:0] coord
);

  localparam int WW = FRAC_BITS + 2;
  localparam int PW = COORD_WIDTH + WW + 1;
  localparam int SW = PW + 2;

  logic signed [PW-1:0] prod_r [4];
  logic signed [SW-1:0] sum;
  logic signed [SW-1:0] shifted;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 4; j++) begin
        prod_r[j] <= PW'(p[j]) * PW'($signed({1'b0, w[j]}));
      end
    end
  end

  always_comb begin
    sum     = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]) + SW'(prod_r[3]);
    shifted = sum >>> FRAC_BITS;
    fits    = (&shifted[SW-1:COORD_WIDTH-1]) || !(|shifted[SW-1:COORD_WIDTH-1]);
    if (fits) begin
      coord = shifted[COORD_WIDTH-1:0];
    end else if (shifted[SW-1]) begin
      coord = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    end else begin
      coord = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    end
  end

endmodule

### src/cubic_bezier_curve_sampler_unit.sv
// Cubic Bezier curve sampler: top level with sequencer and merge stage.
//
// in_chan takes one request holding the four 3D control points (signed
// Q15.16). For it the block emits point_count curve points on out_chan,
// t = i/(point_count-1) in order of i, with sample_index and last_point.
// point_count is written through cfg_wr_en/cfg_wr_data; values below 2 act
// as 2 and values above MAX_POINTS act as MAX_POINTS.
//
// Per request the reciprocal 2^FRAC_BITS/(count-1) is found by a bit-serial
// divider; t then steps by add and compare, one point per cycle while out_chan
// does not stall, through issue register, weight (2 stages), lane (1 stage)
// and output register. A new request is taken once the point pipeline has
// drained; the output register may still hold the last point.
//
// With a point held and out_chan.ready low, the whole point pipeline freezes
// and the output register holds. Reset sets point_count to 16 and empties it.
module cubic_bezier_curve_sampler_unit import cbcs_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [PC_W-1:0] cfg_wr_data,
  cbcs_in_if.sink         in_chan,
  cbcs_out_if.source      out_chan
);

  localparam int CW   = COORD_WIDTH;
  localparam int CNTW = ($clog2(MAX_POINTS + 1) > PC_W) ? $clog2(MAX_POINTS + 1) : PC_W;
  localparam int DW   = CNTW;
  localparam int IW   = $clog2(MAX_POINTS);
  localparam int TW   = FRAC_BITS + 1;
  localparam int WW   = FRAC_BITS + 2;
  localparam int RW   = DW + 2;
  localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

  logic [PC_W-1:0]   pc_r;
  cbcs_state_t       state_r, state_nxt;
  logic [DW-1:0]     d_r;
  logic [IW-1:0]     i_r, i_nxt;
  logic [TW-1:0]     tq_r, tq_nxt;
  logic [RW-1:0]     tr_r, tr_nxt;
  logic signed [CW-1:0] pts_r [3][4];

  logic [CNTW-1:0]   pc_ext, count;
  logic [DW-1:0]     d_nxt;
  logic              en, in_fire, issue, i_last, pipe_busy;
  logic [RW-1:0]     r_sum, twod;

  logic              div_done;
  logic [TW-1:0]     div_quot;
  logic [DW-1:0]     div_rem;

  logic [TW-1:0]     t0_r;
  cbcs_tag_t         tag0_r, tag_w, tag3_r;
  logic [WW-1:0]     w_s2 [4];
  logic              w_busy;
  logic signed [CW-1:0] lane_coord [3];

  logic              out_valid_r;
  logic signed [CW-1:0] out_x_r, out_y_r, out_z_r;
  logic [IDX_W-1:0]  out_idx_r;
  logic              out_last_r;

  // point count register and clamp
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_RESET;
    end else if (cfg_wr_en) begin
      pc_r <= cfg_wr_data;
    end
  end

  always_comb begin
    pc_ext = CNTW'(pc_r);
    if (pc_ext < CNTW'(PC_MIN)) begin
      count = CNTW'(PC_MIN);
    end else if (pc_ext > CNTW'(MAX_POINTS)) begin
      count = CNTW'(MAX_POINTS);
    end else begin
      count = pc_ext;
    end
    d_nxt = count - 1'b1;
  end

  assign en        = !out_valid_r || out_chan.ready;
  assign pipe_busy = tag0_r.valid || w_busy || tag3_r.valid;
  assign in_chan.ready = (state_r == ST_IDLE) && !pipe_busy;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign issue     = (state_r == ST_RUN) && en;
  assign i_last    = (i_r == IW'(d_r));

  cbcs_div #(
    .FRAC_BITS (FRAC_BITS),
    .DW        (DW)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_fire),
    .divisor (d_nxt),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // sequencer: t = round(i/d) by incremental division
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    tq_nxt    = tq_r;
    tr_nxt    = tr_r;
    r_sum     = tr_r + RW'({div_rem, 1'b0});
    twod      = RW'({d_r, 1'b0});
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_RUN;
          i_nxt     = '0;
          tq_nxt    = '0;
          tr_nxt    = RW'(d_r);
        end
      end
      ST_RUN: begin
        if (issue) begin
          i_nxt = i_r + 1'b1;
          if (r_sum >= twod) begin
            tq_nxt = tq_r + div_quot + 1'b1;
            tr_nxt = r_sum - twod;
          end else begin
            tq_nxt = tq_r + div_quot;
            tr_nxt = r_sum;
          end
          if (i_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    i_r  <= i_nxt;
    tq_r <= tq_nxt;
    tr_r <= tr_nxt;
    if (in_fire) begin
      d_r         <= d_nxt;
      pts_r[0][0] <= in_chan.start_x;
      pts_r[1][0] <= in_chan.start_y;
      pts_r[2][0] <= in_chan.start_z;
      pts_r[0][1] <= in_chan.handle_a_x;
      pts_r[1][1] <= in_chan.handle_a_y;
      pts_r[2][1] <= in_chan.handle_a_z;
      pts_r[0][2] <= in_chan.handle_b_x;
      pts_r[1][2] <= in_chan.handle_b_y;
      pts_r[2][2] <= in_chan.handle_b_z;
      pts_r[0][3] <= in_chan.end_x;
      pts_r[1][3] <= in_chan.end_y;
      pts_r[2][3] <= in_chan.end_z;
    end
  end

  // issue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag0_r <= '0;
    end else if (en) begin
      tag0_r <= '{valid: issue, last: i_last, index: IDX_W'(i_r)};
    end
    if (en) begin
      t0_r <= tq_r;
    end
  end

  cbcs_weight #(
    .FRAC_BITS (FRAC_BITS)
  ) u_weight (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .t_in    (t0_r),
    .tag_in  (tag0_r),
    .w_out   (w_s2),
    .tag_out (tag_w),
    .busy    (w_busy)
  );

  for (genvar a = 0; a < 3; a++) begin : g_lane
    cbcs_lane #(
      .COORD_WIDTH (CW),
      .FRAC_BITS   (FRAC_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .p     (pts_r[a]),
      .w     (w_s2),
      .coord (lane_coord[a])
    );
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag3_r      <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      tag3_r      <= tag_w;
      out_valid_r <= tag3_r.valid;
    end
    if (en) begin
      out_x_r    <= lane_coord[0];
      out_y_r    <= lane_coord[1];
      out_z_r    <= lane_coord[2];
      out_idx_r  <= tag3_r.index;
      out_last_r <= tag3_r.last;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.curve_x      = out_x_r;
  assign out_chan.curve_y      = out_y_r;
  assign out_chan.curve_z      = out_z_r;
  assign out_chan.sample_index = out_idx_r;
  assign out_chan.last_point   = out_last_r;

  a_first_t_zero: assert property (@(posedge clk) disable iff (!rst_n)
    issue && (i_r == '0) |=> t0_r == '0)
    else $error("first point t not zero");

  a_last_t_one: assert property (@(posedge clk) disable iff (!rst_n)
    issue && i_last |=> t0_r == T_ONE)
    else $error("last point t not one");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> tr_r < twod)
    else $error("t remainder out of range");

  a_div_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside divide state");

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    tag0_r.valid && tag0_r.last |-> tag0_r.index == IDX_W'(d_r))
    else $error("last flag on wrong index");

endmodule

### verif/cbcs_checker.sv
// Scoreboard for the curve sampler: watches both channels, predicts curve points and compares.
module cbcs_checker import cbcs_pkg::*; #(
  parameter int MAX_POINTS  = 64,
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  logic [PC_W-1:0] cfg_wr_data,
  cbcs_in_if              in_mon,
  cbcs_out_if             out_mon,
  output int              mismatch_count,
  output int              points_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE      = 64'sd1 <<< FRAC_BITS;
  localparam longint HALF     = 64'sd1 <<< (FRAC_BITS - 1);
  localparam longint COORD_HI = (64'sd1 <<< (COORD_WIDTH - 1)) - 1;
  localparam longint COORD_LO = -(64'sd1 <<< (COORD_WIDTH - 1));

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic [IDX_W-1:0]              idx;
    logic                          last;
  } curve_point_t;

  curve_point_t    owed_points[$];
  logic [PC_W-1:0] point_count_q;

  initial begin
    mismatch_count = 0;
    points_owed    = 0;
    point_count_q  = PC_RESET;
  end

  task automatic report_mismatch(input string what, input int pt, input longint got,
                                 input longint want);
    $display("%0t: mismatch in %s at point %0d: got %0d, expected %0d",
             $realtime, what, pt, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    curve_point_t pt;
    longint       ctrl [4][3];
    longint       wt [4];
    longint       coord [3];
    longint       span, t, u, uu, tt, acc;
    int           n;

    if (!rst_n) begin
      point_count_q = PC_RESET;
      owed_points.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (owed_points.size() == 0) begin
          report_mismatch("unrequested point", int'(out_mon.sample_index), 0, -1);
        end else begin
          pt = owed_points.pop_front();
          if (out_mon.curve_x !== pt.x)
            report_mismatch("curve_x", int'(pt.idx), out_mon.curve_x, pt.x);
          if (out_mon.curve_y !== pt.y)
            report_mismatch("curve_y", int'(pt.idx), out_mon.curve_y, pt.y);
          if (out_mon.curve_z !== pt.z)
            report_mismatch("curve_z", int'(pt.idx), out_mon.curve_z, pt.z);
          if (out_mon.sample_index !== pt.idx)
            report_mismatch("sample_index", int'(pt.idx), out_mon.sample_index, pt.idx);
          if (out_mon.last_point !== pt.last)
            report_mismatch("last_point", int'(pt.idx), out_mon.last_point, pt.last);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        n = int'(point_count_q);
        if (n < PC_MIN) n = PC_MIN;
        if (n > MAX_POINTS) n = MAX_POINTS;
        span = longint'(n - 1);
        ctrl[0][0] = longint'($signed(in_mon.start_x));
        ctrl[0][1] = longint'($signed(in_mon.start_y));
        ctrl[0][2] = longint'($signed(in_mon.start_z));
        ctrl[1][0] = longint'($signed(in_mon.handle_a_x));
        ctrl[1][1] = longint'($signed(in_mon.handle_a_y));
        ctrl[1][2] = longint'($signed(in_mon.handle_a_z));
        ctrl[2][0] = longint'($signed(in_mon.handle_b_x));
        ctrl[2][1] = longint'($signed(in_mon.handle_b_y));
        ctrl[2][2] = longint'($signed(in_mon.handle_b_z));
        ctrl[3][0] = longint'($signed(in_mon.end_x));
        ctrl[3][1] = longint'($signed(in_mon.end_y));
        ctrl[3][2] = longint'($signed(in_mon.end_z));
        for (int i = 0; i < n; i++) begin
          // t = i/(n-1) rounded half up in Q1.F, then Bernstein weights
          t  = (longint'(i) * (ONE <<< 1) + span) / (span <<< 1);
          u  = ONE - t;
          uu = (u * u + HALF) >>> FRAC_BITS;
          tt = (t * t + HALF) >>> FRAC_BITS;
          wt[0] = (uu * u + HALF) >>> FRAC_BITS;
          wt[1] = (3 * uu * t + HALF) >>> FRAC_BITS;
          wt[2] = (3 * tt * u + HALF) >>> FRAC_BITS;
          wt[3] = (tt * t + HALF) >>> FRAC_BITS;
          for (int a = 0; a < 3; a++) begin
            acc = 0;
            for (int k = 0; k < 4; k++) acc += ctrl[k][a] * wt[k];
            acc = acc >>> FRAC_BITS;
            if (acc > COORD_HI) acc = COORD_HI;
            if (acc < COORD_LO) acc = COORD_LO;
            coord[a] = acc;
          end
          pt.x    = coord[0][COORD_WIDTH-1:0];
          pt.y    = coord[1][COORD_WIDTH-1:0];
          pt.z    = coord[2][COORD_WIDTH-1:0];
          pt.idx  = IDX_W'(i);
          pt.last = (i == n - 1);
          owed_points.push_back(pt);
        end
      end

      if (cfg_wr_en) point_count_q = cfg_wr_data;
    end
    points_owed = owed_points.size();
  end

endmodule

### verif/cubic_bezier_curve_sampler_unit_tb.sv
// Testbench top for the curve sampler: clock, reset, stimulus, flow control and verdict.
module cubic_bezier_curve_sampler_unit_tb import cbcs_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  FRAC_BITS   = 16;
  localparam int  CYCLE_LIMIT = 500000;
  localparam int  DRAIN_WAIT  = FRAC_BITS + 8;

  localparam logic [31:0] C_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] C_MIN = 32'h8000_0000;

  typedef logic [11:0][31:0] ctrl_set_t;

  logic            clk = 1'b0;
  logic            rst_n;
  logic            cfg_wr_en;
  logic [PC_W-1:0] cfg_wr_data;
  int              mismatch_count;
  int              points_owed;
  int              cycle_count;
  int              send_idle_pct;
  int              recv_stall_pct;

  cbcs_in_if  in_chan ();
  cbcs_out_if out_chan ();

  cubic_bezier_curve_sampler_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_chan     (in_chan),
    .out_chan    (out_chan)
  );

  cbcs_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_mon         (in_chan),
    .out_mon        (out_chan),
    .mismatch_count (mismatch_count),
    .points_owed    (points_owed)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0:       return C_MAX - $urandom_range(0, 3);
      1:       return C_MIN + $urandom_range(0, 3);
      2, 3:    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic ctrl_set_t random_ctrl();
    ctrl_set_t c;
    for (int j = 0; j < 12; j++) c[j] = pick_coord();
    return c;
  endfunction

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic push_curve(input ctrl_set_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.start_x    <= c[0];
    in_chan.start_y    <= c[1];
    in_chan.start_z    <= c[2];
    in_chan.handle_a_x <= c[3];
    in_chan.handle_a_y <= c[4];
    in_chan.handle_a_z <= c[5];
    in_chan.handle_b_x <= c[6];
    in_chan.handle_b_y <= c[7];
    in_chan.handle_b_z <= c[8];
    in_chan.end_x      <= c[9];
    in_chan.end_y      <= c[10];
    in_chan.end_z      <= c[11];
    in_chan.valid      <= 1'b1;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
    @(negedge clk);
  endtask

  task automatic drain_points();
    in_chan.valid <= 1'b0;
    while (points_owed != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_point_count(input logic [PC_W-1:0] value);
    drain_points();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  initial begin
    logic [PC_W-1:0] corner_counts [7];

    corner_counts = '{7'd0, 7'd1, 7'd127, 7'd65, 7'd64, 7'd3, 7'd2};
    cycle_count        = 0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_chan.valid      = 1'b0;
    in_chan.start_x    = '0;
    in_chan.start_y    = '0;
    in_chan.start_z    = '0;
    in_chan.handle_a_x = '0;
    in_chan.handle_a_y = '0;
    in_chan.handle_a_z = '0;
    in_chan.handle_b_x = '0;
    in_chan.handle_b_y = '0;
    in_chan.handle_b_z = '0;
    in_chan.end_x      = '0;
    in_chan.end_y      = '0;
    in_chan.end_z      = '0;
    out_chan.ready     = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset point count, field extremes and saturation
    push_curve('0);
    push_curve({12{C_MAX}});
    push_curve({12{C_MIN}});
    push_curve({6{C_MAX, C_MIN}});
    push_curve({3{C_MAX, C_MIN, C_MIN, C_MAX}});

    // clamped counts below 2 and above the maximum, plus the bounds 64 and 2 and the small count 3
    foreach (corner_counts[j]) begin
      set_point_count(corner_counts[j]);
      push_curve(random_ctrl());
      push_curve({4{C_MIN + $urandom_range(0, 1), C_MAX, 32'h0001_0000}});
    end

    for (int phase = 0; phase < 4; phase++) begin
      for (int s = 0; s < 4; s++) begin
        if (s == 0) begin
          set_point_count(PC_W'($urandom_range(0, 127)));
        end else begin
          set_point_count(PC_W'($urandom_range(2, 12)));
        end
        case (phase)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
          default: begin send_idle_pct = 36; recv_stall_pct = 36; end
        endcase
        repeat (12) push_curve(random_ctrl());
      end
    end

    drain_points();
    if (mismatch_count == 0 && points_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### filelist.f
src/cbcs_pkg.sv
src/cbcs_if.sv
src/cbcs_div.sv
src/cbcs_weight.sv
src/cbcs_lane.sv
src/cubic_bezier_curve_sampler_unit.sv
verif/cbcs_checker.sv
verif/cubic_bezier_curve_sampler_unit_tb.sv
